### rtl/wstfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstfd_pkg
// Shared types and constants for the WebSocket text frame decoder.
// ----------------------------------------------------------------------------
package wstfd_pkg;

   localparam logic [7:0] FRAME_OPENER = 8'h00;
   localparam logic [7:0] FRAME_CLOSER = 8'hFF;

   // UTF-8 lead byte boundaries
   localparam logic [7:0] LEAD_ASCII_END = 8'h80;
   localparam logic [7:0] LEAD_TWO_START = 8'hC2;
   localparam logic [7:0] LEAD_THREE_START = 8'hE0;
   localparam logic [7:0] LEAD_FOUR_START = 8'hF0;
   localparam logic [7:0] LEAD_FOUR_END = 8'hF5;

   // smallest code point per sequence length, surrogate window, upper limit
   localparam logic [20:0] CP_MIN_TWO = 21'h00080;
   localparam logic [20:0] CP_MIN_THREE = 21'h00800;
   localparam logic [20:0] CP_MIN_FOUR = 21'h10000;
   localparam logic [20:0] CP_SURR_LO = 21'h0D800;
   localparam logic [20:0] CP_SURR_HI = 21'h0DFFF;
   localparam logic [20:0] CP_MAX = 21'h10FFFF;

   localparam logic [1:0] SEQ_TWO = 2'd1;
   localparam logic [1:0] SEQ_THREE = 2'd2;
   localparam logic [1:0] SEQ_FOUR = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       is_error;
   } result_type;

endpackage

### rtl/websocket_text_frame_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_text_frame_decoder_core
// Decodes the text frames of a client byte stream into code point bytes.
// ----------------------------------------------------------------------------
// Input channel (req_): one raw client byte per transaction. Bytes outside a
// frame are dropped; 0x00 opens a frame and 0xFF closes it. Inside a frame
// UTF-8 is decoded and each complete code point gives one transaction on
// the result channel (rsp_) carrying its low 8 bits. A malformed sequence
// gives one transaction with rsp_is_error high and rsp_out_byte zero; from
// then on every byte is swallowed until reset.
// Throughput: one byte per clock while the result channel is not stalled.
// A byte accepted into the input register feeds the decode logic, and its
// result is loaded into the result register behind it to show on rsp_valid.
// Bytes that complete nothing produce no transaction.
// Reset (synchronous) empties both registers and returns to waiting for an
// opener. While rsp_stall is high the held result stays put; one more byte
// is held in the input register and req_stall then rises.
// ----------------------------------------------------------------------------
module websocket_text_frame_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_error
);
   import wstfd_pkg::*;

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       advance;
   result_type result;

   assign advance = byte_valid && (!rsp_valid || !rsp_stall);

   wstfd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   wstfd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .byte_data (byte_data),
      .result    (result)
   );

   wstfd_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .result       (result),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_error (rsp_is_error)
   );
endmodule

### rtl/wstfd_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstfd_in_reg
// Input register: holds one received byte until the decoder consumes it.
// ----------------------------------------------------------------------------
module wstfd_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       load;

   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;
   assign byte_in   = (load && req_valid) ? req_in_byte : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;
endmodule

### rtl/wstfd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstfd_decode
// Frame tracking and UTF-8 decode state; one byte per advance.
// ----------------------------------------------------------------------------
module wstfd_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             byte_data,
   output wstfd_pkg::result_type  result
);
   import wstfd_pkg::*;

   logic        in_frame_ff, in_frame_in;
   logic [1:0]  bytes_left_ff, bytes_left_in;
   logic [1:0]  seq_len_ff, seq_len_in;
   logic [20:0] acc_ff, acc_in;
   logic        failed_ff, failed_in;
   logic [20:0] acc_shift;
   logic [20:0] cp_min;
   logic        cp_ok;
   logic        err;

   assign acc_shift = {acc_ff[14:0], byte_data[5:0]};

   always_comb begin
      case (seq_len_ff)
         SEQ_TWO:   cp_min = CP_MIN_TWO;
         SEQ_THREE: cp_min = CP_MIN_THREE;
         default:   cp_min = CP_MIN_FOUR;
      endcase
   end

   assign cp_ok = (acc_shift >= cp_min)
                  && !((acc_shift >= CP_SURR_LO) && (acc_shift <= CP_SURR_HI))
                  && (acc_shift <= CP_MAX);

   always_comb begin
      in_frame_in   = in_frame_ff;
      bytes_left_in = bytes_left_ff;
      seq_len_in    = seq_len_ff;
      acc_in        = acc_ff;
      failed_in     = failed_ff;
      result.valid    = 1'b0;
      result.out_byte = byte_data;
      result.is_error = 1'b0;
      err = 1'b0;

      if (failed_ff) begin
         // silent until reset
      end else if (!in_frame_ff) begin
         if (byte_data == FRAME_OPENER) begin
            in_frame_in = 1'b1;
         end
      end else if (bytes_left_ff == 2'd0) begin
         if (byte_data == FRAME_CLOSER) begin
            in_frame_in = 1'b0;
         end else if (byte_data < LEAD_ASCII_END) begin
            result.valid = 1'b1;
         end else if (byte_data < LEAD_TWO_START) begin
            err = 1'b1;
         end else if (byte_data < LEAD_THREE_START) begin
            bytes_left_in = SEQ_TWO;
            seq_len_in    = SEQ_TWO;
            acc_in        = {16'd0, byte_data[4:0]};
         end else if (byte_data < LEAD_FOUR_START) begin
            bytes_left_in = SEQ_THREE;
            seq_len_in    = SEQ_THREE;
            acc_in        = {17'd0, byte_data[3:0]};
         end else if (byte_data < LEAD_FOUR_END) begin
            bytes_left_in = SEQ_FOUR;
            seq_len_in    = SEQ_FOUR;
            acc_in        = {18'd0, byte_data[2:0]};
         end else begin
            err = 1'b1;
         end
      end else if (byte_data[7:6] != 2'b10) begin
         err = 1'b1;
      end else begin
         acc_in        = acc_shift;
         bytes_left_in = bytes_left_ff - 2'd1;
         if (bytes_left_ff == 2'd1) begin
            if (!cp_ok) begin
               err = 1'b1;
            end else begin
               result.valid    = 1'b1;
               result.out_byte = acc_shift[7:0];
               acc_in          = 21'd0;
               seq_len_in      = 2'd0;
            end
         end
      end

      if (err) begin
         failed_in       = 1'b1;
         in_frame_in     = 1'b0;
         bytes_left_in   = 2'd0;
         seq_len_in      = 2'd0;
         acc_in          = 21'd0;
         result.valid    = 1'b1;
         result.out_byte = 8'd0;
         result.is_error = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         bytes_left_ff <= 2'd0;
         seq_len_ff    <= 2'd0;
         acc_ff        <= 21'd0;
         failed_ff     <= 1'b0;
      end else if (advance) begin
         in_frame_ff   <= in_frame_in;
         bytes_left_ff <= bytes_left_in;
         seq_len_ff    <= seq_len_in;
         acc_ff        <= acc_in;
         failed_ff     <= failed_in;
      end
   end

   a_failed_silent: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> !result.valid)
      else $error("result produced after error");

   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff)
      else $error("error flag cleared without reset");

   a_error_sets_failed: assert property (@(posedge clock) disable iff (reset)
      (advance && result.valid && result.is_error) |=> failed_ff)
      else $error("error result without sticky flag");

   a_seq_in_frame: assert property (@(posedge clock) disable iff (reset)
      (bytes_left_ff != 2'd0) |-> (in_frame_ff && !failed_ff
         && (seq_len_ff >= bytes_left_ff)))
      else $error("sequence state outside a frame");
endmodule

### rtl/wstfd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstfd_out_reg
// Result register: holds a decoded transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module wstfd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  wstfd_pkg::result_type result,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_is_error
);
   import wstfd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       error_ff, error_in;
   logic       load;

   assign load     = advance && result.valid;
   // advance implies any held result has been taken
   assign valid_in = advance ? result.valid : (valid_ff && rsp_stall);
   assign byte_in  = load ? result.out_byte : byte_ff;
   assign error_in = load ? result.is_error : error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff  <= byte_in;
      error_ff <= error_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_error = error_ff;
endmodule
